// File: rtl/hybrid_gshare_perceptron_predictor_assert.svh
// Assertion macros used by the checker file of the predictor.
// HGP_ASSERT_IMP checks an implication in the same cycle, outside reset.
// HGP_ASSERT_NXT checks an implication in the next cycle, outside reset.
// HGP_ASSERT_RST checks what the design shows in the cycle after reset.
`ifndef HYBRID_GSHARE_PERCEPTRON_PREDICTOR_ASSERT_SVH
`define HYBRID_GSHARE_PERCEPTRON_PREDICTOR_ASSERT_SVH

`define HGP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hgp check failed");

`define HGP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hgp check failed");

`define HGP_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("hgp reset check failed");

`endif

// File: rtl/hgp_pkg.sv
// ----------------------------------------------------------------------------
// hgp_pkg
// Shared types and default sizes of the hybrid branch predictor.
// ----------------------------------------------------------------------------
package hgp_pkg;

  // Default table sizes.
  localparam int GshareIndexBits     = 12;
  localparam int PerceptronIndexBits = 7;
  localparam int WeightsPerRow       = 23;
  localparam int ChooserIndexBits    = 9;

  // Field widths.
  localparam int PcWidth     = 32;
  localparam int WeightWidth = 8;
  localparam int ThreshWidth = 8;
  localparam logic [ThreshWidth-1:0] ThreshReset = 8'd7;

  // Reset values of the counter tables.
  localparam logic [1:0] GshareReset  = 2'd1;
  localparam logic [1:0] ChooserReset = 2'd2;

  // One request word as it travels from the front to the back.
  typedef struct packed {
    logic               action;
    logic [PcWidth-1:0] pc;
    logic               outcome;
  } hgp_req_t;

endpackage

// File: rtl/hgp_ram.sv
// ----------------------------------------------------------------------------
// hgp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/hgp_front.sv
// ----------------------------------------------------------------------------
// hgp_front
// Input stage: accepts request words into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hgp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  hgp_pkg::hgp_req_t in_req,
  output logic             head_valid,
  output hgp_pkg::hgp_req_t head,
  input  logic             pop
);

  hgp_pkg::hgp_req_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_req;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/hgp_back.sv
// ----------------------------------------------------------------------------
// hgp_back
// Execution engine: reads the three tables, sums the perceptron row,
// predicts, on training writes the tables back and holds the result word.
// ----------------------------------------------------------------------------
module hgp_back #(
  parameter int GSHARE_INDEX_BITS     = hgp_pkg::GshareIndexBits,
  parameter int PERCEPTRON_INDEX_BITS = hgp_pkg::PerceptronIndexBits,
  parameter int WEIGHTS_PER_ROW       = hgp_pkg::WeightsPerRow,
  parameter int CHOOSER_INDEX_BITS    = hgp_pkg::ChooserIndexBits
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [hgp_pkg::ThreshWidth-1:0]        cfg_wr_data,
  input  logic                                   head_valid,
  input  hgp_pkg::hgp_req_t                      head,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   prediction,
  output logic                                   used_perceptron
);

  localparam int G      = GSHARE_INDEX_BITS;
  localparam int P      = PERCEPTRON_INDEX_BITS;
  localparam int W      = WEIGHTS_PER_ROW;
  localparam int C      = CHOOSER_INDEX_BITS;
  localparam int WW     = hgp_pkg::WeightWidth;
  localparam int ROW_W  = W * WW;
  localparam int HIST_W = (G > W - 1) ? G : W - 1;
  localparam int CLR_A  = (G > P) ? G : P;
  localparam int CLR_B  = (CLR_A > C) ? CLR_A : C;
  localparam int TERM_W = WW + 1;
  localparam int GRP_N  = (W + 7) / 8;
  localparam int GRP_W  = TERM_W + 3;
  localparam int SUM_W  = TERM_W + $clog2(W) + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [CLR_B-1:0]               clr_cnt;
  logic [HIST_W-1:0]              hist;
  logic [hgp_pkg::ThreshWidth-1:0] thresh;
  hgp_pkg::hgp_req_t              req;
  logic signed [GRP_W-1:0]        grp [GRP_N];
  logic signed [GRP_W-1:0]        grp_next [GRP_N];
  logic signed [SUM_W-1:0]        sum;
  logic signed [SUM_W-1:0]        sum_next;

  logic [1:0]       gs_rdata;
  logic [1:0]       ch_rdata;
  logic [ROW_W-1:0] row_rdata;
  logic             clearing;
  logic             fire;
  logic [G-1:0]     gs_raddr;
  logic [G-1:0]     gs_waddr;
  logic [1:0]       gs_wdata;
  logic             gs_we;
  logic [P-1:0]     pc_waddr;
  logic [ROW_W-1:0] row_wdata;
  logic [ROW_W-1:0] row_upd;
  logic             pc_we;
  logic [C-1:0]     ch_waddr;
  logic [1:0]       ch_wdata;
  logic [1:0]       ch_upd;
  logic             ch_we;
  logic             gs_pred;
  logic             pc_pred;
  logic             use_pc;
  logic [SUM_W-1:0] mag;
  logic             train_pc;
  logic             disagree;
  logic [1:0]       gs_upd;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && head_valid;
  assign fire     = (state == S_UPD) && (!out_valid || !out_stall);
  assign gs_raddr = head.pc[G-1:0] ^ hist[G-1:0];

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == {CLR_B{1'b1}}) state_next = S_IDLE;
      S_IDLE:  if (head_valid) state_next = S_SUM;
      S_SUM:   state_next = S_ADD;
      S_ADD:   state_next = S_UPD;
      S_UPD:   if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + CLR_B'(1);
      end
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= hgp_pkg::ThreshReset;
    end else if (cfg_wr_en) begin
      thresh <= cfg_wr_data;
    end
  end

  // Latch the popped request.
  always_ff @(posedge clk) begin
    if (pop) begin
      req <= head;
    end
  end

  // Signed terms, summed in groups of eight.
  always_comb begin
    logic signed [TERM_W-1:0] term;
    logic                     pos;
    for (int g = 0; g < GRP_N; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < 8; k++) begin
        if (g * 8 + k < W) begin
          pos  = (g * 8 + k == W - 1) ? 1'b1 : hist[g * 8 + k];
          term = TERM_W'($signed(row_rdata[(g * 8 + k) * WW +: WW]));
          if (!pos) begin
            term = -term;
          end
          grp_next[g] = grp_next[g] + GRP_W'(term);
        end
      end
    end
  end

  // Final sum over the group totals.
  always_comb begin
    sum_next = '0;
    for (int g = 0; g < GRP_N; g++) begin
      sum_next = sum_next + SUM_W'(grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      for (int g = 0; g < GRP_N; g++) begin
        grp[g] <= grp_next[g];
      end
    end
    if (state == S_ADD) begin
      sum <= sum_next;
    end
  end

  // Prediction and training decisions.
  assign gs_pred  = gs_rdata[1];
  assign use_pc   = ch_rdata[1];
  assign pc_pred  = !sum[SUM_W-1];
  assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign train_pc = (pc_pred != req.outcome) ||
                    (mag <= {{(SUM_W-hgp_pkg::ThreshWidth){1'b0}}, thresh});
  assign disagree = (gs_pred != pc_pred);

  // Saturating counter and weight updates.
  always_comb begin
    if (req.outcome) begin
      gs_upd = (gs_rdata == 2'd3) ? gs_rdata : gs_rdata + 2'd1;
    end else begin
      gs_upd = (gs_rdata == 2'd0) ? gs_rdata : gs_rdata - 2'd1;
    end
    if (gs_pred == req.outcome) begin
      ch_upd = (ch_rdata == 2'd0) ? ch_rdata : ch_rdata - 2'd1;
    end else begin
      ch_upd = (ch_rdata == 2'd3) ? ch_rdata : ch_rdata + 2'd1;
    end
  end

  always_comb begin
    logic signed [WW-1:0] w;
    logic                 pos;
    for (int i = 0; i < W; i++) begin
      w   = $signed(row_rdata[i * WW +: WW]);
      pos = (i == W - 1) ? 1'b1 : hist[i];
      if (pos == req.outcome) begin
        if (w != {1'b0, {(WW-1){1'b1}}}) w = w + $signed(WW'(1));
      end else begin
        if (w != {1'b1, {(WW-1){1'b0}}}) w = w - $signed(WW'(1));
      end
      row_upd[i * WW +: WW] = w;
    end
  end

  // Write ports: reset values during the clearing pass, updates afterwards.
  assign gs_we     = clearing || (fire && req.action);
  assign pc_we     = clearing || (fire && req.action && train_pc);
  assign ch_we     = clearing || (fire && req.action && disagree);
  assign gs_waddr  = clearing ? clr_cnt[G-1:0] : (req.pc[G-1:0] ^ hist[G-1:0]);
  assign pc_waddr  = clearing ? clr_cnt[P-1:0] : req.pc[P-1:0];
  assign ch_waddr  = clearing ? clr_cnt[C-1:0] : req.pc[C-1:0];
  assign gs_wdata  = clearing ? hgp_pkg::GshareReset : gs_upd;
  assign row_wdata = clearing ? '0 : row_upd;
  assign ch_wdata  = clearing ? hgp_pkg::ChooserReset : ch_upd;

  // History shifts on training.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (fire && req.action) begin
      hist <= {hist[HIST_W-2:0], req.outcome};
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prediction      <= use_pc ? pc_pred : gs_pred;
      used_perceptron <= use_pc;
    end
  end

  hgp_ram #(.WIDTH(2), .DEPTH(1 << G)) u_gs_ram (
    .clk(clk), .we(gs_we), .waddr(gs_waddr), .wdata(gs_wdata),
    .re(pop), .raddr(gs_raddr), .rdata(gs_rdata)
  );

  hgp_ram #(.WIDTH(ROW_W), .DEPTH(1 << P)) u_pc_ram (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(row_wdata),
    .re(pop), .raddr(head.pc[P-1:0]), .rdata(row_rdata)
  );

  hgp_ram #(.WIDTH(2), .DEPTH(1 << C)) u_ch_ram (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .re(pop), .raddr(head.pc[C-1:0]), .rdata(ch_rdata)
  );

endmodule

// File: rtl/hybrid_gshare_perceptron_predictor.sv
// ----------------------------------------------------------------------------
// hybrid_gshare_perceptron_predictor
// Flow: the engine takes one queued word at a time and finishes it before it
// pops another: table read, the two-level perceptron adder tree and the table
// write-back; a stalled result word holds the engine until it is taken.
// Reset: clears history, threshold to 7, then a clearing pass over
// 2^max(gshare, perceptron, chooser index bits) addresses (4096) fills the tables.
// ----------------------------------------------------------------------------
module hybrid_gshare_perceptron_predictor #(
  parameter int GSHARE_INDEX_BITS     = hgp_pkg::GshareIndexBits,
  parameter int PERCEPTRON_INDEX_BITS = hgp_pkg::PerceptronIndexBits,
  parameter int WEIGHTS_PER_ROW       = hgp_pkg::WeightsPerRow,
  parameter int CHOOSER_INDEX_BITS    = hgp_pkg::ChooserIndexBits
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [hgp_pkg::ThreshWidth-1:0] cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [hgp_pkg::PcWidth-1:0]     pc,
  input  logic                            outcome,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            prediction,
  output logic                            used_perceptron
);

  hgp_pkg::hgp_req_t in_req;
  hgp_pkg::hgp_req_t head;
  logic              head_valid;
  logic              pop;

  assign in_req.action  = action;
  assign in_req.pc      = pc;
  assign in_req.outcome = outcome;

  // Request queue.
  hgp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .head_valid(head_valid), .head(head), .pop(pop)
  );

  // Prediction and training engine.
  hgp_back #(
    .GSHARE_INDEX_BITS(GSHARE_INDEX_BITS),
    .PERCEPTRON_INDEX_BITS(PERCEPTRON_INDEX_BITS),
    .WEIGHTS_PER_ROW(WEIGHTS_PER_ROW),
    .CHOOSER_INDEX_BITS(CHOOSER_INDEX_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .head_valid(head_valid), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .prediction(prediction), .used_perceptron(used_perceptron)
  );

endmodule

// File: rtl/hgp_checker.sv
// ----------------------------------------------------------------------------
// hgp_checker
// Port-level checks of the predictor, bound to the top level.
// ----------------------------------------------------------------------------
`include "hybrid_gshare_perceptron_predictor_assert.svh"

module hgp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_wr_en,
  input logic [hgp_pkg::ThreshWidth-1:0] cfg_wr_data,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            action,
  input logic [hgp_pkg::PcWidth-1:0]     pc,
  input logic                            outcome,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            prediction,
  input logic                            used_perceptron
);

  // A stalled result word stays and holds its value.
  `HGP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `HGP_ASSERT_NXT(a_out_stable, out_valid && out_stall,
    $stable(prediction) && $stable(used_perceptron))

  // The queue is not full and no result is pending right after reset.
  `HGP_ASSERT_RST(a_rst_no_out, !out_valid)
  `HGP_ASSERT_RST(a_rst_ready, !in_stall)

endmodule

bind hybrid_gshare_perceptron_predictor hgp_checker u_hgp_checker (.*);

// File: dv/tb_hybrid_gshare_perceptron_predictor.sv
// ----------------------------------------------------------------------------
// tb_hybrid_gshare_perceptron_predictor
// Self-checking testbench for the hybrid gshare / perceptron branch predictor.
// A directed table and a stream of random words (mostly loop-like branch
// patterns over a small set of addresses) go through the block. A predictor
// inside the testbench mirrors the counter tables, weights and history, and
// each result word is compared with the oldest expected prediction.
// ----------------------------------------------------------------------------
module tb_hybrid_gshare_perceptron_predictor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GsBits  = hgp_pkg::GshareIndexBits;
  localparam int RowBits = hgp_pkg::PerceptronIndexBits;
  localparam int NumW    = hgp_pkg::WeightsPerRow;
  localparam int ChBits  = hgp_pkg::ChooserIndexBits;
  localparam int NumRand = 1850;
  localparam int WatchdogLimit = 200000;

  localparam logic ActPredict = 1'b0;
  localparam logic ActTrain   = 1'b1;

  typedef struct packed {
    logic prediction;
    logic used_perceptron;
  } branch_result_t;

  typedef struct {
    logic        action;
    logic [31:0] pc;
    logic        outcome;
    logic        has_fixed;
    logic        fixed_prediction;
    logic        fixed_used;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [31:0] pc = '0;
  logic outcome = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic prediction;
  logic used_perceptron;

  // Mirror of the predictor state.
  logic [1:0]  gs_ctr [2**GsBits];
  logic signed [7:0] weight [2**RowBits][NumW];
  logic [1:0]  ch_ctr [2**ChBits];
  logic [31:0] ghist;
  logic [7:0]  threshold;

  branch_result_t expected_q[$];
  int  failures = 0;
  int  idle_cycles = 0;
  bit  stall_random = 1'b1;

  hybrid_gshare_perceptron_predictor i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .pc(pc), .outcome(outcome),
    .out_valid(out_valid), .out_stall(out_stall),
    .prediction(prediction), .used_perceptron(used_perceptron)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic mirror_reset();
    foreach (gs_ctr[i]) gs_ctr[i] = hgp_pkg::GshareReset;
    foreach (ch_ctr[i]) ch_ctr[i] = hgp_pkg::ChooserReset;
    foreach (weight[r, k]) weight[r][k] = '0;
    ghist = '0;
    threshold = hgp_pkg::ThreshReset;
  endtask

  // Predict one branch and, on training, update the mirrored tables.
  function automatic branch_result_t predict_branch(logic act, logic [31:0] addr,
                                                    logic taken);
    branch_result_t res;
    logic [GsBits-1:0] gi;
    logic [RowBits-1:0] row;
    logic [ChBits-1:0] ci;
    logic gs_pred, pc_pred, use_pc, pos;
    int sum, mag, w;
    gi = addr[GsBits-1:0] ^ ghist[GsBits-1:0];
    row = addr[RowBits-1:0];
    ci = addr[ChBits-1:0];
    gs_pred = gs_ctr[gi] >= 2;
    sum = 0;
    for (int k = 0; k < NumW; k++) begin
      pos = (k == NumW - 1) ? 1'b1 : ghist[k];
      sum += pos ? int'(weight[row][k]) : -int'(weight[row][k]);
    end
    pc_pred = sum >= 0;
    use_pc = ch_ctr[ci] >= 2;
    res.prediction = use_pc ? pc_pred : gs_pred;
    res.used_perceptron = use_pc;
    if (act != ActTrain) return res;
    if (taken && gs_ctr[gi] < 3) gs_ctr[gi]++;
    else if (!taken && gs_ctr[gi] > 0) gs_ctr[gi]--;
    mag = sum < 0 ? -sum : sum;
    if (pc_pred != taken || mag <= int'(threshold)) begin
      for (int k = 0; k < NumW; k++) begin
        pos = (k == NumW - 1) ? 1'b1 : ghist[k];
        w = weight[row][k];
        if (pos == taken) begin
          if (w < 127) w++;
        end else if (w > -128) begin
          w--;
        end
        weight[row][k] = w[7:0];
      end
    end
    if (gs_pred != pc_pred) begin
      if (gs_pred == taken) begin
        if (ch_ctr[ci] > 0) ch_ctr[ci]--;
      end else if (ch_ctr[ci] < 3) begin
        ch_ctr[ci]++;
      end
    end
    ghist = {ghist[30:0], taken};
    return res;
  endfunction

  // Send one word; the expectation is pushed when it is accepted.
  task automatic send_word(stim_row_t s);
    int n;
    branch_result_t exp_res;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= s.action;
    pc <= s.pc;
    outcome <= s.outcome;
    do @(posedge clk); while (in_stall);
    exp_res = predict_branch(s.action, s.pc, s.outcome);
    if (s.has_fixed) begin
      exp_res.prediction = s.fixed_prediction;
      exp_res.used_perceptron = s.fixed_used;
    end
    expected_q.push_back(exp_res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = val;
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    branch_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        failures++;
      end else begin
        e = expected_q.pop_front();
        if (prediction !== e.prediction) begin
          $error("prediction expected %0b actual %0b", e.prediction, prediction);
          failures++;
        end
        if (used_perceptron !== e.used_perceptron) begin
          $error("used_perceptron expected %0b actual %0b", e.used_perceptron,
                 used_perceptron);
          failures++;
        end
      end
    end
  end

  // Receiver stalls: random bursts, with stretches of none.
  always @(posedge clk) begin
    if (!stall_random) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 30) out_stall <= ($urandom_range(0, 9) < 9);
    else out_stall <= 1'b0;
  end

  // Watchdog on cycles with no accepted word and no result word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("hybrid_gshare_perceptron_predictor: mismatch");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_table[$];
    stim_row_t s;
    logic [31:0] loop_pc [8];
    int phase;
    mirror_reset();
    // Directed rows: fresh tables predict through the perceptron (sum 0 => taken).
    dir_table.push_back('{ActPredict, 32'h0, 1'b1, 1'b1, 1'b1, 1'b1});
    dir_table.push_back('{ActPredict, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1});
    dir_table.push_back('{ActTrain, 32'h0, 1'b0, 1'b1, 1'b1, 1'b1});
    dir_table.push_back('{ActTrain, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0});
    dir_table.push_back('{ActTrain, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0});
    dir_table.push_back('{ActTrain, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0});
    for (int i = 0; i < 8; i++)
      dir_table.push_back('{ActTrain, 32'h0000_0040, 1'b0, 1'b0, 1'b0, 1'b0});
    for (int i = 0; i < 6; i++)
      dir_table.push_back('{ActTrain, 32'h8000_0040, 1'b1, 1'b0, 1'b0, 1'b0});
    dir_table.push_back('{ActPredict, 32'h0000_0040, 1'b1, 1'b0, 1'b0, 1'b0});
    dir_table.push_back('{ActPredict, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) send_word(dir_table[i]);

    // Random phases over several thresholds, extremes included.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_threshold(8'd0);
        1: write_threshold(8'd255);
        2: write_threshold(8'($urandom_range(1, 254)));
        3: write_threshold(8'd7);
        default: write_threshold(8'($urandom_range(0, 40)));
      endcase
      stall_random = (phase != 2);
      foreach (loop_pc[k]) loop_pc[k] = $urandom;
      // Long training runs drive weights to saturation.
      if (phase == 1) foreach (loop_pc[k]) loop_pc[k][6:0] = 7'h15;
      for (int i = 0; i < NumRand / 5; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          s.pc = loop_pc[$urandom_range(0, 7)];
          s.action = ($urandom_range(0, 9) < 8) ? ActTrain : ActPredict;
          s.outcome = (phase == 1) ? ($urandom_range(0, 19) != 0)
                                   : (s.pc[3] ^ ($urandom_range(0, 9) == 0));
        end else begin
          s.pc = $urandom;
          s.action = $urandom_range(0, 1);
          s.outcome = $urandom_range(0, 1);
        end
        s.has_fixed = 1'b0;
        s.fixed_prediction = 1'b0;
        s.fixed_used = 1'b0;
        send_word(s);
        if (i == 100) drain();
      end
    end
    stall_random = 1'b0;
    drain();
    if (failures == 0) begin
      $display("hybrid_gshare_perceptron_predictor: match");
    end else begin
      $display("hybrid_gshare_perceptron_predictor: mismatch");
    end
    $finish;
  end

  // A result still missing at the end leaves the queue non-empty; the
  // watchdog then ends the run as a failure.
endmodule
